[design/efr_pkg.sv]
// Shared codes and types for the escaped frame receiver.
`default_nettype none
package efr_pkg;

  // Framing codes on the serial byte stream.
  localparam logic [7:0] CODE_START  = 8'hFA;
  localparam logic [7:0] CODE_END    = 8'hFD;
  localparam logic [7:0] CODE_ESCAPE = 8'hFE;

  localparam int LEN_W      = 6;   // payload count field width
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 16; // payload byte + length, padded to bytes

  // One accepted frame handed from the parser to the drain side.
  typedef struct packed {
    logic             bank;
    logic [LEN_W-1:0] len;
  } desc_t;

  // Bank handed back to the parser once its last byte has been read.
  typedef struct packed {
    logic valid;
    logic bank;
  } rel_t;

  // One result item as held in the output buffer.
  typedef struct packed {
    logic [7:0]       data;
    logic             last;
    logic [LEN_W-1:0] len;
  } out_item_t;

endpackage
`default_nettype wire

[design/efr_parse.sv]
// Front end: unescapes the byte stream, writes frame bytes and checks frames.
`default_nettype none
module efr_parse #(
  parameter int BUF_DEPTH = 64
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output      logic                        in_ready,
  input  wire logic [7:0]                  in_byte,
  output      logic                        wr_en,
  output      logic [$clog2(BUF_DEPTH):0]  wr_addr,
  output      logic [7:0]                  wr_data,
  output      logic                        push,
  output      efr_pkg::desc_t              push_desc,
  input  wire efr_pkg::rel_t               rel
);

  localparam int AW = $clog2(BUF_DEPTH);
  localparam int FW = $clog2(BUF_DEPTH + 1);

  typedef enum logic {ST_IDLE, ST_FRAME} state_t;

  state_t        state_r, state_nxt;
  logic          esc_r, esc_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic [7:0]    chk_r, chk_nxt;
  logic [1:0]    busy_r, busy_nxt;
  logic          bank_r, bank_nxt;
  logic          accept;
  logic          do_store;
  logic          good;
  logic [FW-1:0] fill_inc;

  assign in_ready = !busy_r[bank_r];
  assign accept   = in_valid && in_ready;
  assign fill_inc = fill_r + FW'(1);
  assign good     = (fill_r >= FW'(2)) && (chk_r == 8'h00);

  assign wr_addr = {bank_r, fill_r[AW-1:0]};
  assign wr_data = in_byte;
  assign wr_en   = do_store;

  always_comb begin
    state_nxt = state_r;
    esc_nxt   = esc_r;
    fill_nxt  = fill_r;
    chk_nxt   = chk_r;
    bank_nxt  = bank_r;
    busy_nxt  = busy_r;
    do_store  = 1'b0;
    push      = 1'b0;
    push_desc.bank = bank_r;
    push_desc.len  = efr_pkg::LEN_W'(fill_r - FW'(1));
    if (rel.valid) begin
      busy_nxt[rel.bank] = 1'b0;
    end
    if (accept) begin
      unique case (state_r)
        ST_IDLE: begin
          if (esc_r) begin
            esc_nxt = 1'b0;            // byte after an idle escape is skipped
          end else if (in_byte == efr_pkg::CODE_START) begin
            state_nxt = ST_FRAME;
            fill_nxt  = '0;
            chk_nxt   = '0;
          end else if (in_byte == efr_pkg::CODE_ESCAPE) begin
            esc_nxt = 1'b1;
          end
        end
        ST_FRAME: begin
          if (esc_r) begin
            esc_nxt = 1'b0;
            if (in_byte == efr_pkg::CODE_START || in_byte == efr_pkg::CODE_END ||
                in_byte == efr_pkg::CODE_ESCAPE) begin
              do_store = 1'b1;
            end else begin
              state_nxt = ST_IDLE;     // bad escape drops the frame
            end
          end else if (in_byte == efr_pkg::CODE_START) begin
            fill_nxt = '0;             // restart inside a frame
            chk_nxt  = '0;
          end else if (in_byte == efr_pkg::CODE_END) begin
            state_nxt = ST_IDLE;
            if (good) begin
              push             = 1'b1;
              busy_nxt[bank_r] = 1'b1;
              bank_nxt         = ~bank_r;
            end
          end else if (in_byte == efr_pkg::CODE_ESCAPE) begin
            esc_nxt = 1'b1;
          end else begin
            do_store = 1'b1;
          end
        end
        default: state_nxt = ST_IDLE;
      endcase
      if (do_store) begin
        chk_nxt  = chk_r ^ in_byte;
        fill_nxt = fill_inc;
        if (fill_inc == FW'(BUF_DEPTH)) begin
          state_nxt = ST_IDLE;         // store full drops the frame
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      esc_r   <= 1'b0;
      fill_r  <= '0;
      chk_r   <= '0;
      busy_r  <= '0;
      bank_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      esc_r   <= esc_nxt;
      fill_r  <= fill_nxt;
      chk_r   <= chk_nxt;
      busy_r  <= busy_nxt;
      bank_r  <= bank_nxt;
    end
  end

`ifndef SYNTHESIS
  // a frame is never committed into a bank still being drained
  a_push_free_bank: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !busy_r[bank_r])
    else $error("frame committed into busy bank");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(BUF_DEPTH))
    else $error("fill count beyond store depth");
`endif

endmodule
`default_nettype wire

[design/efr_queue.sv]
// Two-entry queue of committed frame descriptors.
`default_nettype none
module efr_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire efr_pkg::desc_t push_desc,
  input  wire logic           pop,
  output      logic           q_valid,
  output      efr_pkg::desc_t q_desc
);

  efr_pkg::desc_t slot_r [2];
  logic           wptr_r, rptr_r;
  logic [1:0]     cnt_r;

  assign q_valid = (cnt_r != 2'd0);
  assign q_desc  = slot_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= ~wptr_r;
      end
      if (pop) begin
        rptr_r <= ~rptr_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (cnt_r != 2'd2) || pop)
    else $error("descriptor queue overflow");
`endif

endmodule
`default_nettype wire

[design/efr_drain.sv]
// Back end: double-banked frame store and byte-by-byte output drain.
`default_nettype none
module efr_drain #(
  parameter int BUF_DEPTH = 64
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        wr_en,
  input  wire logic [$clog2(BUF_DEPTH):0]  wr_addr,
  input  wire logic [7:0]                  wr_data,
  input  wire logic                        q_valid,
  input  wire efr_pkg::desc_t              q_desc,
  output      logic                        q_pop,
  output      efr_pkg::rel_t               rel,
  output      logic                        out_valid,
  input  wire logic                        out_ready,
  output      efr_pkg::out_item_t          out_item
);

  localparam int AW = $clog2(BUF_DEPTH);
  localparam int LW = efr_pkg::LEN_W;

  logic [7:0]         mem [2**(AW+1)];
  logic [7:0]         rdata_r;
  logic               active_r;
  logic               bank_r;
  logic [LW-1:0]      len_r;
  logic [LW-1:0]      idx_r;
  logic               infl_r;
  logic               meta_last_r;
  logic [LW-1:0]      meta_len_r;
  efr_pkg::out_item_t ob_r [2];
  logic               ob_wr_r, ob_rd_r;
  logic [1:0]         ob_cnt_r;
  logic [1:0]         occ;
  logic               out_fire;
  logic               ren;
  logic               last_issue;
  logic [AW:0]        raddr;

  assign out_valid  = (ob_cnt_r != 2'd0);
  assign out_item   = ob_r[ob_rd_r];
  assign out_fire   = out_valid && out_ready;
  assign occ        = ob_cnt_r + {1'b0, infl_r};
  // a read is issued only when its data is sure to find a buffer slot
  assign ren        = active_r && ((occ < 2'd2) || out_fire);
  assign last_issue = (idx_r == len_r - LW'(1));
  assign raddr      = {bank_r, idx_r[AW-1:0]};
  assign q_pop      = !active_r && q_valid;
  assign rel.valid  = ren && last_issue;
  assign rel.bank   = bank_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ren) begin
      rdata_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (ren) begin
      meta_last_r <= last_issue;
      meta_len_r  <= len_r;
    end
    if (q_pop) begin
      bank_r <= q_desc.bank;
      len_r  <= q_desc.len;
    end
    if (infl_r) begin
      ob_r[ob_wr_r] <= '{data: rdata_r, last: meta_last_r, len: meta_len_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      idx_r    <= '0;
      infl_r   <= 1'b0;
      ob_wr_r  <= 1'b0;
      ob_rd_r  <= 1'b0;
      ob_cnt_r <= '0;
    end else begin
      infl_r <= ren;
      if (q_pop) begin
        active_r <= 1'b1;
        idx_r    <= '0;
      end else if (ren) begin
        idx_r <= idx_r + LW'(1);
        if (last_issue) begin
          active_r <= 1'b0;
        end
      end
      if (infl_r) begin
        ob_wr_r <= ~ob_wr_r;
      end
      if (out_fire) begin
        ob_rd_r <= ~ob_rd_r;
      end
      ob_cnt_r <= ob_cnt_r + {1'b0, infl_r} - {1'b0, out_fire};
    end
  end

`ifndef SYNTHESIS
  a_ob_credit: assert property (@(posedge clk) disable iff (!rst_n)
    occ <= 2'd2)
    else $error("output buffer overcommitted");
`endif

endmodule
`default_nettype wire

[design/escaped_frame_receiver_unit.sv]
// Top level of the escaped frame receiver: byte-stuffed deframer with XOR check.
`default_nettype none
// Receives one raw byte per in_ item and rebuilds frames that open with 0xFA,
// close with 0xFD and use 0xFE to escape the next byte. A frame that closes
// with at least two bytes and an XOR of zero over all of them is sent out on
// out_, one item per payload byte (check byte left off), with tlast on the
// final byte and the payload count beside every byte; all other frames are
// dropped silently. Rate: the input side takes one byte per cycle as long as
// the bank it is filling is free. The store has two banks of BUF_DEPTH bytes,
// so one frame can be drained while the next is received; the input stalls
// only when a good frame closes while the other bank is still draining, and
// then until the last byte of that frame has been read from the store. The
// output side delivers one byte per cycle while out_tready stays high, from
// a store read port with a registered result. With the back end idle, the
// first byte of a frame shows on out_tvalid after its close byte is accepted,
// via descriptor pop, store read and output buffer write; a frame queued
// behind another is popped only after the previous frame's last read issues.
// A two-entry output buffer keeps the read stream running under back-pressure.
// No clearing pass is needed after reset.
module escaped_frame_receiver_unit #(
  parameter int BUF_DEPTH = 64
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output      logic                             in_tready,
  input  wire logic [efr_pkg::IN_TDATA_W-1:0]   in_tdata,   // [7:0] rx_byte
  output      logic                             out_tvalid,
  input  wire logic                             out_tready,
  output      logic [efr_pkg::OUT_TDATA_W-1:0]  out_tdata,  // [7:0] payload_byte,
                                                            // [13:8] frame_length
  output      logic                             out_tlast   // last_of_frame
);

  localparam int AW = $clog2(BUF_DEPTH);

  logic               wr_en;
  logic [AW:0]        wr_addr;
  logic [7:0]         wr_data;
  logic               push;
  efr_pkg::desc_t     push_desc;
  logic               q_valid;
  efr_pkg::desc_t     q_desc;
  logic               q_pop;
  efr_pkg::rel_t      rel;
  efr_pkg::out_item_t out_item;

  // front end: parsing, escape handling, store writes, frame check
  efr_parse #(.BUF_DEPTH(BUF_DEPTH)) u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_byte   (in_tdata[7:0]),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .push      (push),
    .push_desc (push_desc),
    .rel       (rel)
  );

  // committed frames waiting for the drain
  efr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .q_desc    (q_desc)
  );

  // back end: store banks, readout and output buffer
  efr_drain #(.BUF_DEPTH(BUF_DEPTH)) u_drain (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .q_valid   (q_valid),
    .q_desc    (q_desc),
    .q_pop     (q_pop),
    .rel       (rel),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_item  (out_item)
  );

  assign out_tdata = {2'b00, out_item.len, out_item.data};
  assign out_tlast = out_item.last;

endmodule
`default_nettype wire
